FILE: rtl/srm_pkg.sv
package srm_pkg;

  typedef enum logic [4:0] {
    OP_LIT = 5'd1, OP_RTN = 5'd2, OP_LOD = 5'd3, OP_STO = 5'd4, OP_CAL = 5'd5,
    OP_INC = 5'd6, OP_JMP = 5'd7, OP_JPC = 5'd8, OP_WRT = 5'd9, OP_RED = 5'd10,
    OP_HLT = 5'd11, OP_NEG = 5'd12, OP_ADD = 5'd13, OP_SUB = 5'd14,
    OP_MUL = 5'd15, OP_DIV = 5'd16, OP_ODD = 5'd17, OP_MOD = 5'd18,
    OP_EQL = 5'd19, OP_NEQ = 5'd20, OP_LSS = 5'd21, OP_LEQ = 5'd22,
    OP_GTR = 5'd23, OP_GEQ = 5'd24
  } opcode_e;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0, ST_HALT = 3'd1, ST_BADOP = 3'd2, ST_DIVZ = 3'd3, ST_RANGE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_WALK_RD, S_WALK_WT, S_ACCESS, S_ACC_WT, S_RTN_RD,
    S_RTN_WT, S_CALL_WR, S_DIV, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    C_NONE, C_CLEAR, C_DECODE, C_WALK_RD, C_WALK_LATCH, C_ACCESS, C_ACC_DONE,
    C_RTN_RD, C_RTN_DONE, C_CALL_WR, C_DIV_START, C_DIV_STEP, C_STORE_RESULT
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic need_walk;
    logic walk_done;
    logic is_mem;
    logic is_rtn;
    logic is_cal;
    logic is_div;
    logic fault;
    logic call_done;
    logic div_done;
    logic stopped;
    logic rtn_second;
  } stat_t;

endpackage

FILE: rtl/srm_ctrl.sv
module srm_ctrl
  import srm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctrl_o.cmd = C_NONE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.cmd = C_CLEAR;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = C_DECODE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.stopped || stat_i.fault) state_d = S_OUT;
        else if (stat_i.need_walk) state_d = S_WALK_RD;
        else if (stat_i.is_rtn) begin
          ctrl_o.cmd = C_RTN_RD;
          state_d = S_RTN_WT;
        end else if (stat_i.is_cal) state_d = S_CALL_WR;
        else if (stat_i.is_mem) state_d = S_ACCESS;
        else if (stat_i.is_div) begin
          ctrl_o.cmd = C_DIV_START;
          state_d = S_DIV;
        end else begin
          ctrl_o.cmd = C_STORE_RESULT;
          state_d = S_OUT;
        end
      end
      S_WALK_RD: begin
        if (stat_i.fault) state_d = S_OUT;
        else if (stat_i.walk_done) begin
          if (stat_i.is_cal) state_d = S_CALL_WR;
          else state_d = S_ACCESS;
        end else begin
          ctrl_o.cmd = C_WALK_RD;
          state_d = S_WALK_WT;
        end
      end
      S_WALK_WT: begin
        ctrl_o.cmd = C_WALK_LATCH;
        state_d = S_WALK_RD;
      end
      S_ACCESS: begin
        ctrl_o.cmd = C_ACCESS;
        state_d = S_ACC_WT;
      end
      S_ACC_WT: begin
        ctrl_o.cmd = C_ACC_DONE;
        state_d = S_OUT;
      end
      S_RTN_RD: begin
        ctrl_o.cmd = C_RTN_RD;
        state_d = S_RTN_WT;
      end
      S_RTN_WT: begin
        ctrl_o.cmd = C_RTN_DONE;
        if (stat_i.rtn_second) state_d = S_OUT;
        else state_d = S_RTN_RD;
      end
      S_CALL_WR: begin
        ctrl_o.cmd = C_CALL_WR;
        if (stat_i.call_done) state_d = S_OUT;
      end
      S_DIV: begin
        ctrl_o.cmd = C_DIV_STEP;
        if (stat_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/srm_dp.sv
module srm_dp
  import srm_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512,
  parameter int WORD_BITS   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctrl_t                          ctrl_i,
  output stat_t                          stat_o,
  input  logic [4:0]                     opcode_i,
  input  logic [2:0]                     reg_index_i,
  input  logic [2:0]                     level_offset_i,
  input  logic signed [31:0]             operand_i,
  input  logic signed [31:0]             read_value_i,
  output logic [$clog2(CODE_DEPTH)-1:0]  next_pc_o,
  output logic [$clog2(STACK_DEPTH)-1:0] frame_base_out_o,
  output logic [$clog2(STACK_DEPTH)-1:0] stack_top_out_o,
  output logic                           write_valid_o,
  output logic signed [31:0]             write_value_o,
  output logic [2:0]                     status_o
);

  localparam int PW = $clog2(CODE_DEPTH);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = WORD_BITS + 2;
  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [EW-1:0] DEPTH_E = EW'(STACK_DEPTH);

  logic [WORD_BITS-1:0] mem_q [STACK_DEPTH];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] regs_q [8];

  logic [PW-1:0] pc_q;
  logic [AW-1:0] bp_q, sp_q;
  logic          stopped_q;
  logic [AW:0]   clr_q;

  logic [4:0]           op_q;
  logic [2:0]           r_q, lv_q;
  logic [WORD_BITS-1:0] m_q, x_q, y_q, rv_q;
  logic [2:0]           st_q;
  logic                 wv_q;
  logic [WORD_BITS-1:0] wval_q;
  logic [2:0]           cnt_q;
  logic [WORD_BITS-1:0] base_q;
  logic                 rtn2_q;
  logic [WORD_BITS-1:0] ret_q;

  logic [WORD_BITS-1:0] quo_q, rem_q, dvs_q;
  logic [CW-1:0]        dcnt_q;

  function automatic logic [EW-1:0] sx(input logic [WORD_BITS-1:0] w);
    sx = {{2{w[WORD_BITS-1]}}, w};
  endfunction

  function automatic logic in_rng(input logic [EW-1:0] a);
    in_rng = !a[EW-1] && (a < DEPTH_E);
  endfunction

  function automatic logic [WORD_BITS-1:0] ext32(input logic [31:0] v);
    ext32 = WORD_BITS'($signed(v));
  endfunction

  logic [EW-1:0] walk_addr, acc_addr, inc_addr;
  logic [AW-1:0] fr1;
  assign walk_addr = sx(base_q) + EW'(cnt_q);
  assign acc_addr  = sx(base_q) + sx(ext32(m_q[31:0]));
  assign inc_addr  = EW'(sp_q) + sx(ext32(m_q[31:0]));
  assign fr1       = bp_q - AW'(1);

  logic [WORD_BITS-1:0] x_mag, y_mag;
  assign x_mag = x_q[WORD_BITS-1] ? -x_q : x_q;
  assign y_mag = y_q[WORD_BITS-1] ? -y_q : y_q;

  logic [WORD_BITS:0] trial;
  assign trial = {rem_q, quo_q[WORD_BITS-1]} - {1'b0, dvs_q};

  logic [WORD_BITS-1:0] alu;
  logic                 lt_xy, lt_yx;
  assign lt_xy = $signed(x_q) < $signed(y_q);
  assign lt_yx = $signed(y_q) < $signed(x_q);
  always_comb begin
    case (opcode_e'(op_q))
      OP_LIT:  alu = ext32(m_q[31:0]);
      OP_RED:  alu = rv_q;
      OP_NEG:  alu = -regs_q[r_q];
      OP_ADD:  alu = x_q + y_q;
      OP_SUB:  alu = x_q - y_q;
      OP_MUL:  alu = x_q * y_q;
      OP_ODD:  alu = !regs_q[r_q][0] ? '0 :
                     (regs_q[r_q][WORD_BITS-1] ? '1 : WORD_BITS'(1));
      OP_EQL:  alu = WORD_BITS'(x_q == y_q);
      OP_NEQ:  alu = WORD_BITS'(x_q != y_q);
      OP_LSS:  alu = WORD_BITS'(lt_xy);
      OP_LEQ:  alu = WORD_BITS'(!lt_yx);
      OP_GTR:  alu = WORD_BITS'(lt_yx);
      OP_GEQ:  alu = WORD_BITS'(!lt_xy);
      default: alu = regs_q[r_q];
    endcase
  end

  logic [PW-1:0] pc_inc;
  assign pc_inc = (pc_q == PW'(CODE_DEPTH - 1)) ? '0 : pc_q + PW'(1);

  logic dec_fault;
  logic [2:0] dec_st;
  always_comb begin
    dec_fault = 1'b0;
    dec_st = ST_RUN;
    case (opcode_e'(opcode_i))
      OP_HLT: begin dec_fault = 1'b1; dec_st = ST_HALT; end
      OP_DIV, OP_MOD: if (regs_q[operand_i[2:0]] == '0) begin
        dec_fault = 1'b1; dec_st = ST_DIVZ;
      end
      OP_RTN: if (bp_q == '0 || !in_rng(EW'(bp_q) + EW'(3))) begin
        dec_fault = 1'b1; dec_st = ST_RANGE;
      end
      OP_INC: if (!in_rng(EW'(sp_q) + sx(ext32(operand_i)))) begin
        dec_fault = 1'b1; dec_st = ST_RANGE;
      end
      OP_CAL: if (!in_rng(EW'(sp_q) + EW'(4))) begin
        dec_fault = 1'b1; dec_st = ST_RANGE;
      end
      OP_LIT, OP_LOD, OP_STO, OP_JMP, OP_JPC, OP_WRT, OP_RED, OP_NEG, OP_ADD,
      OP_SUB, OP_MUL, OP_ODD, OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR, OP_GEQ: ;
      default: begin dec_fault = 1'b1; dec_st = ST_BADOP; end
    endcase
  end

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [WORD_BITS-1:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (ctrl_i.cmd)
      C_CLEAR: begin mem_we = 1'b1; mem_wa = clr_q[AW-1:0]; end
      C_WALK_RD: mem_ra = walk_addr[AW-1:0];
      C_ACCESS: begin
        mem_ra = acc_addr[AW-1:0];
        if (op_q == OP_STO && in_rng(acc_addr)) begin
          mem_we = 1'b1; mem_wa = acc_addr[AW-1:0]; mem_wd = regs_q[r_q];
        end
      end
      // return address first, then the dynamic link
      C_RTN_RD: mem_ra = rtn2_q ? fr1 + AW'(3) : fr1 + AW'(4);
      C_CALL_WR: begin
        mem_we = 1'b1;
        mem_wa = sp_q + AW'(cnt_q) + AW'(1);
        case (cnt_q)
          3'd0: mem_wd = '0;
          3'd1: mem_wd = base_q;
          3'd2: mem_wd = WORD_BITS'(bp_q);
          default: mem_wd = WORD_BITS'(pc_q);
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; bp_q <= AW'(1); sp_q <= '0; stopped_q <= 1'b0; clr_q <= '0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
      op_q <= '0; r_q <= '0; lv_q <= '0; m_q <= '0; x_q <= '0; y_q <= '0;
      rv_q <= '0; st_q <= '0; wv_q <= 1'b0; wval_q <= '0; cnt_q <= '0;
      base_q <= '0; rtn2_q <= 1'b0; ret_q <= '0;
      quo_q <= '0; rem_q <= '0; dvs_q <= '0; dcnt_q <= '0;
    end else begin
      case (ctrl_i.cmd)
        C_CLEAR: clr_q <= clr_q + (AW+1)'(1);
        C_DECODE: begin
          op_q <= opcode_i; r_q <= reg_index_i; lv_q <= level_offset_i;
          m_q <= WORD_BITS'(unsigned'(operand_i));
          rv_q <= ext32(read_value_i);
          x_q <= regs_q[level_offset_i]; y_q <= regs_q[operand_i[2:0]];
          wv_q <= 1'b0; wval_q <= '0; rtn2_q <= 1'b0;
          cnt_q <= level_offset_i; base_q <= WORD_BITS'(bp_q);
          if (stopped_q) st_q <= ST_HALT;
          else begin
            pc_q <= pc_inc;
            st_q <= dec_st;
            if (dec_fault) stopped_q <= 1'b1;
            case (opcode_e'(opcode_i))
              OP_JMP: pc_q <= PW'(unsigned'(operand_i));
              OP_JPC: if (regs_q[reg_index_i] == '0) pc_q <= PW'(unsigned'(operand_i));
              OP_WRT: begin wv_q <= 1'b1; wval_q <= regs_q[reg_index_i]; end
              OP_INC: if (!dec_fault)
                sp_q <= AW'(EW'(sp_q) + sx(ext32(operand_i)));
              OP_CAL: cnt_q <= level_offset_i;
              default: ;
            endcase
          end
        end
        C_WALK_RD: if (!in_rng(walk_addr)) begin
          st_q <= ST_RANGE; stopped_q <= 1'b1;
        end
        C_WALK_LATCH: begin base_q <= rdata_q; cnt_q <= cnt_q - 3'd1; end
        C_ACCESS: if (!in_rng(acc_addr)) begin
          st_q <= ST_RANGE; stopped_q <= 1'b1;
        end
        C_ACC_DONE: if (st_q == ST_RUN && op_q == OP_LOD) regs_q[r_q] <= rdata_q;
        C_RTN_DONE: begin
          if (!rtn2_q) begin
            ret_q <= rdata_q; rtn2_q <= 1'b1;
          end else if (!in_rng(sx(rdata_q))) begin
            st_q <= ST_RANGE; stopped_q <= 1'b1;
          end else begin
            pc_q <= PW'(ret_q); sp_q <= fr1; bp_q <= rdata_q[AW-1:0];
          end
        end
        C_CALL_WR: begin
          if (cnt_q == 3'd3) begin
            bp_q <= sp_q + AW'(1); pc_q <= PW'(m_q); cnt_q <= '0;
          end else cnt_q <= cnt_q + 3'd1;
        end
        C_DIV_START: begin
          quo_q <= x_mag; rem_q <= '0; dvs_q <= y_mag; dcnt_q <= '0;
        end
        C_DIV_STEP: begin
          if (dcnt_q == CW'(WORD_BITS)) begin
            if (op_q == OP_DIV)
              regs_q[r_q] <= (x_q[WORD_BITS-1] ^ y_q[WORD_BITS-1]) ? -quo_q : quo_q;
            else regs_q[r_q] <= x_q[WORD_BITS-1] ? -rem_q : rem_q;
          end else begin
            dcnt_q <= dcnt_q + CW'(1);
            if (!trial[WORD_BITS]) begin
              rem_q <= trial[WORD_BITS-1:0]; quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
              quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
            end
          end
        end
        C_STORE_RESULT: if (op_q != OP_JMP && op_q != OP_JPC && op_q != OP_WRT &&
                            op_q != OP_INC) regs_q[r_q] <= alu;
        default: ;
      endcase
    end
  end

  assign stat_o.clear_done = (clr_q == (AW+1)'(STACK_DEPTH - 1)) && ctrl_i.cmd == C_CLEAR;
  assign stat_o.need_walk  = (op_q == OP_LOD || op_q == OP_STO || op_q == OP_CAL) &&
                             lv_q != '0;
  assign stat_o.walk_done  = cnt_q == '0 || !(op_q == OP_LOD || op_q == OP_STO ||
                             op_q == OP_CAL) ? 1'b1 : 1'b0;
  assign stat_o.is_mem     = op_q == OP_LOD || op_q == OP_STO;
  assign stat_o.is_rtn     = op_q == OP_RTN;
  assign stat_o.is_cal     = op_q == OP_CAL;
  assign stat_o.is_div     = op_q == OP_DIV || op_q == OP_MOD;
  assign stat_o.fault      = st_q != ST_RUN;
  assign stat_o.call_done  = cnt_q == 3'd3;
  assign stat_o.div_done   = dcnt_q == CW'(WORD_BITS);
  assign stat_o.stopped    = st_q == ST_HALT && !stopped_q ? 1'b0 : (st_q == ST_HALT);
  assign stat_o.rtn_second = rtn2_q;

  assign next_pc_o        = pc_q;
  assign frame_base_out_o = bp_q;
  assign stack_top_out_o  = sp_q;
  assign write_valid_o    = wv_q;
  assign write_value_o    = wval_q[31:0];
  assign status_o         = st_q;

endmodule

FILE: rtl/stack_register_machine_execute.sv
// Register, jump, I/O and faulting ops go from decode straight to the result; LOD/STO and
// CAL first walk the static chain, one read per level, then LOD/STO access the stack and
// CAL writes its frame; RTN reads two frame words; DIV/MOD make one quotient bit per cycle.
// One item in flight. Reset: asynchronous active low; then a clearing pass zeroes the
// stack memory before the first item is accepted.
module stack_register_machine_execute
  import srm_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512,
  parameter int WORD_BITS   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [4:0]                     opcode_i,
  input  logic [2:0]                     reg_index_i,
  input  logic [2:0]                     level_offset_i,
  input  logic signed [31:0]             operand_i,
  input  logic signed [31:0]             read_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [$clog2(CODE_DEPTH)-1:0]  next_pc_o,
  output logic [$clog2(STACK_DEPTH)-1:0] frame_base_out_o,
  output logic [$clog2(STACK_DEPTH)-1:0] stack_top_out_o,
  output logic                           write_valid_o,
  output logic signed [31:0]             write_value_o,
  output logic [2:0]                     status_o
);

  ctrl_t ctrl;
  stat_t stat;

  srm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  srm_dp #(
    .STACK_DEPTH(STACK_DEPTH), .CODE_DEPTH(CODE_DEPTH), .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .opcode_i, .reg_index_i, .level_offset_i, .operand_i, .read_value_i,
    .next_pc_o, .frame_base_out_o, .stack_top_out_o, .write_valid_o,
    .write_value_o, .status_o
  );

endmodule

FILE: rtl/srm_checker.sv
module srm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        write_valid_o,
  input logic [31:0] write_value_o,
  input logic [2:0]  status_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_wv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_value_o == '0) else $error("stray write value");

  a_status_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'd4) else $error("bad status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");

endmodule

bind stack_register_machine_execute srm_checker u_chk (.*);

FILE: tb/stack_register_machine_execute_test.sv
module stack_register_machine_execute_test;
  import srm_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [4:0]  op;
    logic [2:0]  rsel;
    logic [2:0]  lsel;
    logic [31:0] opnd;
    logic [31:0] rdv;
  } instr_t;

  typedef struct {
    logic [8:0]  pc;
    logic [9:0]  fb;
    logic [9:0]  sp;
    logic        wvalid;
    logic [31:0] wv;
    logic [2:0]  st;
  } outcome_t;

  typedef struct {
    instr_t   ins;
    bit       typed;
    outcome_t exp;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [4:0] opcode_i;
  logic [2:0] reg_index_i, level_offset_i;
  logic signed [31:0] operand_i, read_value_i;
  logic [8:0] next_pc_o;
  logic [9:0] frame_base_out_o, stack_top_out_o;
  logic write_valid_o;
  logic signed [31:0] write_value_o;
  logic [2:0] status_o;

  stack_register_machine_execute DUT (.*);

  // machine state mirror
  int          pc_m, fb_m, sp_m;
  logic [31:0] regs_m [8];
  logic [31:0] stack_m [1024];
  bit          stopped_m;

  outcome_t pending_q [$];
  row_t     plan_q [$];
  int       mismatches, accepted, writes_seen, stall_cnt, cyc;
  bit       quiet_tx;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit in_stack(longint a);
    return a >= 0 && a < 1024;
  endfunction

  // Executes one instruction on the mirror; only commits when apply is set.
  function automatic outcome_t execute_instr(instr_t c, bit apply);
    outcome_t    o;
    logic [31:0] x, y, rv;
    bit          wr_reg, fault;
    int          npc, nfb, nsp;
    longint      b, a, ms, t, q;
    int          k;
    o.wvalid = 1'b0;
    o.wv = '0;
    o.st = ST_RUN;
    if (stopped_m) begin
      o.st = ST_HALT;
    end else begin
      x = regs_m[c.lsel];
      y = regs_m[c.opnd[2:0]];
      ms = longint'($signed(c.opnd));
      npc = (pc_m + 1) % 512;
      nfb = fb_m;
      nsp = sp_m;
      wr_reg = 1'b0;
      rv = '0;
      fault = 1'b0;
      b = fb_m;
      if (c.op == OP_LOD || c.op == OP_STO || c.op == OP_CAL) begin
        for (k = c.lsel; k > 0; k--) begin
          a = b + k;
          if (!in_stack(a)) begin
            fault = 1'b1;
            break;
          end
          b = longint'($signed(stack_m[a]));
        end
      end
      case (c.op)
        OP_LIT: begin wr_reg = 1; rv = c.opnd; end
        OP_RTN: begin
          t = fb_m - 1;
          if (t < 0 || !in_stack(t + 4)) o.st = ST_RANGE;
          else begin
            a = longint'($signed(stack_m[t + 3]));
            if (!in_stack(a)) o.st = ST_RANGE;
            else begin
              npc = stack_m[t + 4] % 512;
              nsp = int'(t);
              nfb = int'(a);
            end
          end
        end
        OP_LOD, OP_STO: begin
          a = b + ms;
          if (fault || !in_stack(a)) o.st = ST_RANGE;
          else if (c.op == OP_LOD) begin
            wr_reg = 1;
            rv = stack_m[a];
          end else if (apply) stack_m[a] = regs_m[c.rsel];
        end
        OP_CAL: begin
          if (fault || !in_stack(sp_m + 4)) o.st = ST_RANGE;
          else begin
            if (apply) begin
              stack_m[sp_m + 1] = '0;
              stack_m[sp_m + 2] = b[31:0];
              stack_m[sp_m + 3] = fb_m;
              stack_m[sp_m + 4] = npc;
            end
            nfb = sp_m + 1;
            npc = c.opnd % 512;
          end
        end
        OP_INC: begin
          a = sp_m + ms;
          if (!in_stack(a)) o.st = ST_RANGE;
          else nsp = int'(a);
        end
        OP_JMP: npc = c.opnd % 512;
        OP_JPC: if (regs_m[c.rsel] == 0) npc = c.opnd % 512;
        OP_WRT: begin o.wvalid = 1; o.wv = regs_m[c.rsel]; end
        OP_RED: begin wr_reg = 1; rv = c.rdv; end
        OP_HLT: o.st = ST_HALT;
        OP_NEG: begin wr_reg = 1; rv = -regs_m[c.rsel]; end
        OP_ADD: begin wr_reg = 1; rv = x + y; end
        OP_SUB: begin wr_reg = 1; rv = x - y; end
        OP_MUL: begin wr_reg = 1; rv = x * y; end
        OP_DIV, OP_MOD: begin
          if (y == 0) o.st = ST_DIVZ;
          else begin
            if (c.op == OP_DIV) q = longint'($signed(x)) / longint'($signed(y));
            else q = longint'($signed(x)) % longint'($signed(y));
            wr_reg = 1;
            rv = q[31:0];
          end
        end
        OP_ODD: begin
          wr_reg = 1;
          rv = !regs_m[c.rsel][0] ? 32'd0 : (regs_m[c.rsel][31] ? '1 : 32'd1);
        end
        OP_EQL: begin wr_reg = 1; rv = 32'(x == y); end
        OP_NEQ: begin wr_reg = 1; rv = 32'(x != y); end
        OP_LSS: begin wr_reg = 1; rv = 32'($signed(x) < $signed(y)); end
        OP_LEQ: begin wr_reg = 1; rv = 32'($signed(x) <= $signed(y)); end
        OP_GTR: begin wr_reg = 1; rv = 32'($signed(x) > $signed(y)); end
        OP_GEQ: begin wr_reg = 1; rv = 32'($signed(x) >= $signed(y)); end
        default: o.st = ST_BADOP;
      endcase
      if (apply) begin
        if (o.st == ST_RUN) begin
          pc_m = npc;
          fb_m = nfb;
          sp_m = nsp;
          if (wr_reg) regs_m[c.rsel] = rv;
        end else begin
          pc_m = (pc_m + 1) % 512;
          stopped_m = 1'b1;
        end
      end
    end
    if (apply) begin
      o.pc = pc_m[8:0];
      o.fb = fb_m[9:0];
      o.sp = sp_m[9:0];
    end
    return o;
  endfunction

  function automatic instr_t mk(logic [4:0] op, int r, int l, logic [31:0] opnd,
                                logic [31:0] rdv = 0);
    instr_t c;
    c.op = op;
    c.rsel = 3'(r);
    c.lsel = 3'(l);
    c.opnd = opnd;
    c.rdv = rdv;
    return c;
  endfunction

  function automatic instr_t random_instr();
    instr_t c;
    int     sel, tries;
    for (tries = 0; tries < 20; tries++) begin
      c = mk(OP_LIT, $urandom_range(0, 7), $urandom_range(0, 7), $urandom, $urandom);
      sel = $urandom_range(0, 99);
      if (sel < 10) c.op = OP_LIT;
      else if (sel < 18) begin
        c.op = OP_INC;
        if ($urandom_range(0, 19) == 0) c.opnd = int'($urandom_range(0, 1023)) - sp_m;
        else c.opnd = int'($urandom_range(0, 16)) - 6;
      end else if (sel < 26) begin
        c.op = OP_CAL;
        c.lsel = 3'($urandom_range(0, 2));
      end else if (sel < 32) c.op = OP_RTN;
      else if (sel < 44) begin
        c.op = ($urandom_range(0, 1)) ? OP_LOD : OP_STO;
        c.lsel = 3'($urandom_range(0, 2));
        c.opnd = $urandom_range(0, 8);
      end else if (sel < 48) c.op = OP_JMP;
      else if (sel < 53) c.op = OP_JPC;
      else if (sel < 59) c.op = OP_WRT;
      else if (sel < 63) c.op = OP_RED;
      else c.op = 5'($urandom_range(OP_NEG, OP_GEQ));
      if (execute_instr(c, 0).st == ST_RUN) return c;
    end
    return mk(OP_LIT, $urandom_range(0, 7), 0, $urandom);
  endfunction

  function automatic row_t plain(instr_t c);
    row_t r;
    r.ins = c;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic row_t typed_row(instr_t c, int pc, int fb, int sp, bit wvalid,
                                     logic [31:0] wv, logic [2:0] st);
    row_t r;
    r.ins = c;
    r.typed = 1'b1;
    r.exp.pc = 9'(pc);
    r.exp.fb = 10'(fb);
    r.exp.sp = 10'(sp);
    r.exp.wvalid = wvalid;
    r.exp.wv = wv;
    r.exp.st = st;
    return r;
  endfunction

  task automatic send_item(instr_t c, bit typed, outcome_t typed_exp);
    outcome_t o;
    o = execute_instr(c, 1);
    pending_q.push_back(typed ? typed_exp : o);
    while (!quiet_tx && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= c.op;
    reg_index_i <= c.rsel;
    level_offset_i <= c.lsel;
    operand_i <= c.opnd;
    read_value_i <= c.rdv;
    do @(posedge clk_i); while (!in_ready_o);
    accepted++;
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cnt);
      $display("*** FAILED ***");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cyc);
      end else begin
        outcome_t e;
        e = pending_q.pop_front();
        if (write_valid_o) writes_seen++;
        if (next_pc_o !== e.pc || frame_base_out_o !== e.fb || stack_top_out_o !== e.sp ||
            write_valid_o !== e.wvalid || write_value_o !== e.wv || status_o !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cyc %0d: exp pc=%0d fb=%0d sp=%0d wv=%0b/%h st=%0d, got %0d %0d %0d %0b/%h %0d",
                     cyc, e.pc, e.fb, e.sp, e.wvalid, e.wv, e.st, next_pc_o,
                     frame_base_out_o, stack_top_out_o, write_valid_o, write_value_o,
                     status_o);
        end
      end
    end
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= (cyc > 9000 && cyc < 14000) || ($urandom_range(0, 99) >= 12);
  end

  initial begin
    outcome_t none;
    int i, kind;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    opcode_i = '0;
    reg_index_i = '0;
    level_offset_i = '0;
    operand_i = '0;
    read_value_i = '0;
    mismatches = 0;
    accepted = 0;
    writes_seen = 0;
    stall_cnt = 0;
    cyc = 0;
    quiet_tx = 1'b0;
    pc_m = 0;
    fb_m = 1;
    sp_m = 0;
    stopped_m = 1'b0;
    foreach (regs_m[j]) regs_m[j] = '0;
    foreach (stack_m[j]) stack_m[j] = '0;
    none = '{default: '0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan_q.push_back(typed_row(mk(OP_LIT, 0, 0, 32'h8000_0000), 1, 1, 0, 0, 0, ST_RUN));
    plan_q.push_back(plain(mk(OP_LIT, 1, 0, 32'hffff_ffff)));
    plan_q.push_back(plain(mk(OP_DIV, 2, 0, 1)));
    plan_q.push_back(plain(mk(OP_MOD, 3, 0, 1)));
    plan_q.push_back(typed_row(mk(OP_WRT, 2, 0, 0), 5, 1, 0, 1, 32'h8000_0000, ST_RUN));
    plan_q.push_back(plain(mk(OP_LIT, 4, 0, 32'h7fff_ffff)));
    plan_q.push_back(plain(mk(OP_ADD, 5, 4, 4)));
    plan_q.push_back(plain(mk(OP_MUL, 6, 4, 1)));
    plan_q.push_back(plain(mk(OP_SUB, 7, 0, 4)));
    plan_q.push_back(plain(mk(OP_NEG, 0, 0, 0)));
    plan_q.push_back(plain(mk(OP_ODD, 1, 0, 0)));
    plan_q.push_back(plain(mk(OP_EQL, 2, 0, 2)));
    plan_q.push_back(plain(mk(OP_NEQ, 3, 4, 5)));
    plan_q.push_back(plain(mk(OP_LSS, 4, 1, 7)));
    plan_q.push_back(plain(mk(OP_LEQ, 5, 6, 6)));
    plan_q.push_back(plain(mk(OP_GTR, 6, 7, 3)));
    plan_q.push_back(plain(mk(OP_GEQ, 7, 2, 0)));
    plan_q.push_back(plain(mk(OP_RED, 3, 0, 0, 32'hdead_beef)));
    plan_q.push_back(plain(mk(OP_INC, 0, 0, 1019)));
    plan_q.push_back(typed_row(mk(OP_CAL, 0, 0, 32'hffff_ffff), 511, 1020, 1019, 0, 0,
                               ST_RUN));
    plan_q.push_back(plain(mk(OP_STO, 3, 0, 0)));
    plan_q.push_back(plain(mk(OP_LOD, 4, 1, 0)));
    plan_q.push_back(plain(mk(OP_JPC, 7, 0, 100)));
    plan_q.push_back(plain(mk(OP_JMP, 0, 0, 32'hffff_fe00)));
    plan_q.push_back(plain(mk(OP_RTN, 0, 0, 0)));
    plan_q.push_back(plain(mk(OP_INC, 0, 0, -1019)));

    foreach (plan_q[j]) send_item(plan_q[j].ins, plan_q[j].typed, plan_q[j].exp);

    for (i = 0; i < NUM_RANDOM; i++) begin
      quiet_tx = (i >= 500 && i < 800);
      if (i == 1000) begin
        in_valid_i <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk_i);
      end
      send_item(random_instr(), 0, none);
    end

    // one stop condition per run, then a few items into the stopped machine
    kind = $urandom_range(0, 3);
    case (kind)
      0: send_item(mk(OP_HLT, 0, 0, 0), 0, none);
      1: send_item(mk($urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(25, 31)), 0, 0, 0),
                   0, none);
      2: begin
        send_item(mk(OP_LIT, 0, 0, 0), 0, none);
        send_item(mk($urandom_range(0, 1) ? OP_DIV : OP_MOD, 1, 2, 0), 0, none);
      end
      default: send_item(mk(OP_INC, 0, 0, -2000), 0, none);
    endcase
    repeat (4) send_item(random_instr(), 0, none);
    in_valid_i <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("%0d instructions executed, %0d output values, stop kind %0d", accepted,
             writes_seen, kind);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
